FILE: rtl/core/slru_pkg.sv
// Package for the size-bounded LRU cache unit: payload structs, event codes
// and default constants. No dependencies.
`timescale 1ns / 1ps
package slru_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam logic [30:0] DefaultLimit = 31'd1000000;
  localparam int unsigned BytesW = 27;

  typedef enum logic [1:0] {
    EvEvict    = 2'd0,
    EvHit      = 2'd1,
    EvMiss     = 2'd2,
    EvInserted = 2'd3
  } event_kind_e;

  typedef enum logic {
    ActFind   = 1'b0,
    ActInsert = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [31:0] lookup_key;
    logic [31:0] object_handle;
    logic [12:0] object_width;
    logic [12:0] object_height;
    logic [5:0]  bits_per_pixel;
  } req_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] result_handle;
    logic [31:0] result_key;
    logic        last_of_run;
  } rsp_t;

endpackage

FILE: rtl/core/size_bounded_lru_cache_unit.sv
// Size-bounded LRU cache unit: entry table, walk sequencer, size multiply.
// Depends on slru_pkg.
`timescale 1ns / 1ps
// Usage: pulse start_i with req_i while busy_o is low. The unit answers with
// one or more rsp_o beats, each shown for one cycle with rsp_valid_o; the
// beat carrying last_of_run ends the run and busy_o drops in the cycle after it.
// The receiver cannot stall, so it must take every beat as it comes. All
// table searches walk one entry per cycle through a single key/rank compare:
// a find walks the table at most once; an insert walks it for the key search
// and the free-slot search plus once more per eviction, with the size multiply
// in StMul1 and StMul2 after the key search. Write size_limit via
// cfg_we_i/cfg_wdata_i only while busy_o is low.
module size_bounded_lru_cache_unit
  import slru_pkg::*;
#(
  parameter int unsigned ENTRIES = DefaultEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  output logic        rsp_valid_o,
  output rsp_t        rsp_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSrch = 4'd1;
  localparam logic [3:0] StMul1 = 4'd2;
  localparam logic [3:0] StMul2 = 4'd3;
  localparam logic [3:0] StChk  = 4'd4;
  localparam logic [3:0] StLru  = 4'd5;
  localparam logic [3:0] StFree = 4'd6;
  localparam logic [3:0] StEnd  = 4'd7;

  logic [3:0]        state_q;
  logic [IW-1:0]     idx_q;
  logic [CW-1:0]     count_q;
  logic [ENTRIES-1:0] valid_q;
  logic [31:0]       key_q    [ENTRIES];
  logic [31:0]       handle_q [ENTRIES];
  logic [BytesW-1:0] bytes_q  [ENTRIES];
  logic [IW-1:0]     rank_q   [ENTRIES];
  logic [31:0]       total_q;
  logic [30:0]       limit_q;
  req_t              req_q;
  logic [25:0]       prod_q;
  logic [BytesW-1:0] size_q;
  logic              rsp_valid_q;
  rsp_t              rsp_q;

  logic              key_match, lru_match;
  logic [28:0]       size_full;
  logic [IW-1:0]     cur_rank;

  assign cur_rank  = rank_q[idx_q];
  assign key_match = valid_q[idx_q] && (key_q[idx_q] == req_q.lookup_key);
  assign lru_match = valid_q[idx_q] && (CW'(cur_rank) == count_q - CW'(1));
  assign size_full = {3'd0, prod_q} * {26'd0, req_q.bits_per_pixel[5:3]};

  assign busy_o      = (state_q != StIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DefaultLimit;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      req_q <= req_i;
    end
    if (state_q == StMul1) begin
      prod_q <= {14'd0, req_q.object_width[11:0]} * {14'd0, req_q.object_height[11:0]}
                + {req_q.object_width[12] ? {1'b0, req_q.object_height, 12'd0} : 26'd0}
                + {req_q.object_height[12] ? {2'b0, req_q.object_width[11:0], 12'd0}
                                           : 26'd0};
    end
    if (state_q == StMul2) begin
      size_q <= (|size_full[28:27]) ? {BytesW{1'b1}} : size_full[BytesW-1:0];
    end
    unique case (state_q)
      StSrch: begin
        if (key_match && req_q.action == ActFind) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && rank_q[i] < cur_rank) rank_q[i] <= rank_q[i] + IW'(1);
          end
          rank_q[idx_q] <= '0;
          rsp_q <= '{EvHit, handle_q[idx_q], req_q.lookup_key, 1'b1};
        end else if (key_match) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && rank_q[i] > cur_rank) rank_q[i] <= rank_q[i] - IW'(1);
          end
          rsp_q <= '{EvEvict, handle_q[idx_q], key_q[idx_q], 1'b0};
        end else if (idx_q == LastIdx && req_q.action == ActFind) begin
          rsp_q <= '{EvMiss, 32'd0, req_q.lookup_key, 1'b1};
        end
      end
      StLru: begin
        if (lru_match) begin
          rsp_q <= '{EvEvict, handle_q[idx_q], key_q[idx_q], 1'b0};
        end
      end
      StFree: begin
        if (!valid_q[idx_q]) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i]) rank_q[i] <= rank_q[i] + IW'(1);
          end
          rank_q[idx_q]   <= '0;
          key_q[idx_q]    <= req_q.lookup_key;
          handle_q[idx_q] <= req_q.object_handle;
          bytes_q[idx_q]  <= size_q;
          rsp_q <= '{EvInserted, req_q.object_handle, req_q.lookup_key, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      count_q     <= '0;
      valid_q     <= '0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (start_i) state_q <= StSrch;
        end
        StSrch: begin
          idx_q <= idx_q + IW'(1);
          if (key_match) begin
            rsp_valid_q <= 1'b1;
            if (req_q.action == ActFind) begin
              state_q <= StEnd;
            end else begin
              valid_q[idx_q] <= 1'b0;
              count_q <= count_q - CW'(1);
              total_q <= total_q - {5'd0, bytes_q[idx_q]};
              state_q <= StMul1;
            end
          end else if (idx_q == LastIdx) begin
            if (req_q.action == ActFind) begin
              rsp_valid_q <= 1'b1;
              state_q <= StEnd;
            end else begin
              state_q <= StMul1;
            end
          end
        end
        StMul1: state_q <= StMul2;
        StMul2: begin
          total_q <= total_q + {3'd0, size_full[28:27] != 2'd0 ? 29'h7FFFFFF : size_full};
          state_q <= StChk;
        end
        StChk: begin
          idx_q <= '0;
          if ((total_q > {1'b0, limit_q} && count_q != '0) || count_q >= CW'(ENTRIES)) begin
            state_q <= StLru;
          end else begin
            state_q <= StFree;
          end
        end
        StLru: begin
          idx_q <= idx_q + IW'(1);
          if (lru_match) begin
            rsp_valid_q    <= 1'b1;
            valid_q[idx_q] <= 1'b0;
            count_q <= count_q - CW'(1);
            total_q <= total_q - {5'd0, bytes_q[idx_q]};
            state_q <= StChk;
          end
        end
        StFree: begin
          idx_q <= idx_q + IW'(1);
          if (!valid_q[idx_q]) begin
            rsp_valid_q    <= 1'b1;
            valid_q[idx_q] <= 1'b1;
            count_q <= count_q + CW'(1);
            state_q <= StEnd;
          end
        end
        StEnd: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench for size_bounded_lru_cache_unit: directed and random find/insert traffic,
// checked against a behavioral LRU table model. Depends on slru_pkg and the unit RTL.
`timescale 1ns / 1ps
module tb_top
  import slru_pkg::*;
();

  localparam int Ways = 16;
  localparam logic [26:0] BytesMax = 27'h7FFFFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  size_bounded_lru_cache_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i), .busy_o(busy_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .rsp_valid_o(rsp_valid_o),
    .rsp_o(rsp_o)
  );

  // cache table model
  logic [30:0] limit_q;
  logic        slot_used [Ways];
  logic [31:0] slot_key [Ways];
  logic [31:0] slot_handle [Ways];
  logic [26:0] slot_bytes [Ways];
  int          slot_age [Ways];
  logic [31:0] bytes_used;
  rsp_t        pending_rsp [$];
  int          errors = 0;
  int          beats_seen = 0;
  int          hits_seen = 0;
  int          evicts_seen = 0;
  logic [31:0] key_pool [8];

  function automatic int used_count();
    int c;
    c = 0;
    for (int i = 0; i < Ways; i++) if (slot_used[i]) c++;
    return c;
  endfunction

  function automatic int oldest_slot();
    int b;
    b = -1;
    for (int i = 0; i < Ways; i++)
      if (slot_used[i] && (b < 0 || slot_age[i] > slot_age[b])) b = i;
    return b;
  endfunction

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < Ways; i++) if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void push_rsp(event_kind_e ev, logic [31:0] h, logic [31:0] k);
    rsp_t r;
    r.event_kind = ev;
    r.result_handle = h;
    r.result_key = k;
    r.last_of_run = 1'b0;
    pending_rsp.push_back(r);
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < Ways; i++)
      if (slot_used[i] && slot_age[i] > slot_age[s]) slot_age[i]--;
    bytes_used -= 32'(slot_bytes[s]);
    slot_used[s] = 1'b0;
    push_rsp(EvEvict, slot_handle[s], slot_key[s]);
  endfunction

  function automatic void predict_request(req_t rq);
    int s;
    int free_s;
    logic [63:0] sz;
    s = find_slot(rq.lookup_key);
    if (rq.action == ActFind) begin
      if (s >= 0) begin
        for (int i = 0; i < Ways; i++)
          if (slot_used[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
        slot_age[s] = 0;
        push_rsp(EvHit, slot_handle[s], rq.lookup_key);
      end else begin
        push_rsp(EvMiss, 32'd0, rq.lookup_key);
      end
    end else begin
      if (s >= 0) drop_slot(s);
      sz = 64'(rq.object_width) * 64'(rq.object_height) * 64'(rq.bits_per_pixel / 8);
      if (sz > 64'(BytesMax)) sz = 64'(BytesMax);
      bytes_used += 32'(sz);
      while (bytes_used > 32'(limit_q) && used_count() > 0) drop_slot(oldest_slot());
      if (used_count() >= Ways) drop_slot(oldest_slot());
      free_s = 0;
      for (int i = Ways - 1; i >= 0; i--) if (!slot_used[i]) free_s = i;
      for (int i = 0; i < Ways; i++) if (slot_used[i]) slot_age[i]++;
      slot_used[free_s] = 1'b1;
      slot_key[free_s] = rq.lookup_key;
      slot_handle[free_s] = rq.object_handle;
      slot_bytes[free_s] = sz[26:0];
      slot_age[free_s] = 0;
      push_rsp(EvInserted, rq.object_handle, rq.lookup_key);
    end
    pending_rsp[pending_rsp.size() - 1].last_of_run = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && rsp_valid_o) begin
      beats_seen++;
      if (rsp_o.event_kind == EvHit) hits_seen++;
      if (rsp_o.event_kind == EvEvict) evicts_seen++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, rsp_o);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_o !== exp_rsp) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_rsp, rsp_o);
          errors++;
        end
      end
    end
  end

  task automatic send_request(req_t rq);
    repeat ($urandom_range(0, 7)) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    req_i <= rq;
    start_i <= 1'b1;
    @(posedge clk_i);
    predict_request(rq);
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic drain_and_settle();
    int guard;
    guard = 0;
    while ((pending_rsp.size() != 0 || busy_o) && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (2 * Ways + 8) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [30:0] v);
    drain_and_settle();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_q = v;
  endtask

  function automatic req_t make_req(logic act, logic [31:0] k, logic [31:0] h,
                                    logic [12:0] w, logic [12:0] ht, logic [5:0] d);
    req_t r;
    r.action = act;
    r.lookup_key = k;
    r.object_handle = h;
    r.object_width = w;
    r.object_height = ht;
    r.bits_per_pixel = d;
    return r;
  endfunction

  task automatic test_directed();
    send_request(make_req(ActFind, 32'hFFFF_FFFF, 32'd0, 13'd0, 13'd0, 6'd0));
    send_request(make_req(ActInsert, 32'h0, 32'hFFFF_FFFF, 13'd0, 13'd4096, 6'd32));
    send_request(make_req(ActInsert, 32'hFFFF_FFFF, 32'h0, 13'd10, 13'd10, 6'd7));
    send_request(make_req(ActFind, 32'h0, 32'd0, 13'h1FFF, 13'h1FFF, 6'h3F));
    send_request(make_req(ActInsert, 32'h0, 32'h1234, 13'd4, 13'd4, 6'd8));
    // over budget object, then oversize saturation
    send_request(make_req(ActInsert, 32'h55, 32'hA5A5_5A5A, 13'd4096, 13'd4096, 6'd32));
    send_request(make_req(ActInsert, 32'hAA, 32'h5A5A_A5A5, 13'h1FFF, 13'h1FFF, 6'h3F));
    // fill the table past its capacity with zero-size entries
    for (int i = 0; i < 18; i++)
      send_request(make_req(ActInsert, 32'h100 + i, 32'h200 + i, 13'd1, 13'd1, 6'd0));
    send_request(make_req(ActFind, 32'h102, 32'd0, 13'd0, 13'd0, 6'd0));
  endtask

  task automatic test_limit_extremes();
    write_limit(31'd0);
    send_request(make_req(ActInsert, 32'h300, 32'h1, 13'd0, 13'd0, 6'd8));
    send_request(make_req(ActInsert, 32'h301, 32'h2, 13'd1, 13'd1, 6'd8));
    write_limit(31'h7FFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_request(make_req(ActInsert, 32'h310 + i, 32'h10 + i, 13'd4096, 13'd4096, 6'd32));
    write_limit(31'd100);
    send_request(make_req(ActInsert, 32'h320, 32'h3, 13'd2, 13'd2, 6'd8));
  endtask

  task automatic test_random(int count, logic [30:0] lim);
    req_t rq;
    write_limit(lim);
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      rq = req_t'({1'($urandom()), $urandom(), $urandom(), $urandom()});
      if ($urandom_range(0, 9) != 0) rq.lookup_key = key_pool[3'($urandom_range(0, 7))]
        ^ 32'($urandom_range(0, 3));
      if ($urandom_range(0, 9) != 0) begin
        rq.object_width = 13'($urandom_range(0, 64));
        rq.object_height = 13'($urandom_range(0, 64));
        rq.bits_per_pixel = 6'($urandom_range(0, 32));
      end
      send_request(rq);
    end
  endtask

  initial begin
    limit_q = DefaultLimit;
    bytes_used = 0;
    for (int i = 0; i < Ways; i++) begin
      slot_used[i] = 1'b0;
      slot_age[i] = 0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_limit_extremes();
    test_random(150, 31'd20000);
    test_random(150, 31'd200000);
    test_random(125, DefaultLimit);
    drain_and_settle();
    $display("Covered %0d beats: %0d hits, %0d evictions or drops.",
             beats_seen, hits_seen, evicts_seen);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: size_bounded_lru_cache_unit.f
rtl/core/slru_pkg.sv
rtl/core/size_bounded_lru_cache_unit.sv
dv/tb_top.sv
